// File: design/lgs_pkg.sv
// shared types, constants and functions for the life generation stencil
package lgs_pkg;

   // configuration port
   localparam int CFG_W       = 11;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CFG_W-1:0] GRID_RESET = 11'd1024;
   localparam int MIN_GRID    = 3;

   // response queue depth
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = RSP_PTR_W + 1;

   // life rule constants
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1
   } csr_index_type;

   // per-cell control bits from the raster position logic
   typedef struct packed {
      logic produce;
      logic row_done;
      logic frame_done;
   } cell_flags_type;

   // one response transaction
   typedef struct packed {
      logic next_alive;
      logic row_done;
      logic frame_done;
   } rsp_item_type;

   // b3/s23 rule on a 3x3 window, center at bit 4
   function automatic logic life_rule(input logic [8:0] win);
      logic [3:0] count;
      count = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            count = count + 4'(win[i]);
         end
      end
      return (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && win[4]);
   endfunction

endpackage

// File: design/lgs_req_if.sv
// request channel: one raster cell per transaction
interface lgs_req_if;
   logic valid;
   logic ready;
   logic cell_alive;
   logic frame_start;

   modport source (output valid, output cell_alive, output frame_start, input ready);
   modport sink   (input valid, input cell_alive, input frame_start, output ready);
endinterface

// File: design/lgs_rsp_if.sv
// response channel: next state of one interior cell per transaction
interface lgs_rsp_if;
   logic valid;
   logic ready;
   logic next_alive;
   logic row_done;
   logic frame_done;

   modport source (output valid, output next_alive, output row_done, output frame_done,
                   input ready);
   modport sink   (input valid, input next_alive, input row_done, input frame_done,
                   output ready);
endinterface

// File: design/lgs_csr_if.sv
// configuration write channel
interface lgs_csr_if import lgs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/life_generation_stencil_top.sv
// life generation stencil: one b3/s23 generation over a raster-streamed grid
// a result passes through the stencil register stage and the response queue before it is offered
// throughput: one cell per cycle given queue room, bound by the line memory's one read and write
// reset: grid size registers return to 1024 and position to row 0, column 0
// after reset the line memory is cleared entry by entry with req not ready
// configuration writes are taken at any time, one per cycle
module life_generation_stencil_top import lgs_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic         clock,
   input  logic         reset,
   lgs_req_if.sink      req_bus,
   lgs_rsp_if.source    rsp_bus,
   lgs_csr_if.sink      csr_bus
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic                 req_accept;
   logic                 rsp_pop;
   logic                 clearing;
   logic                 busy;
   logic                 push;
   logic                 upper, middle;
   logic [CW-1:0]        col;
   logic [RSP_CNT_W-1:0] queue_count;
   logic [RSP_CNT_W-1:0] reserved;
   cell_flags_type       flags;
   rsp_item_type         push_item;
   rsp_item_type         head_item;
   logic                 not_empty;

   // accept a cell only when not clearing and the queue can absorb it and the one in flight
   always_comb begin
      reserved      = queue_count + RSP_CNT_W'(busy);
      req_bus.ready = !clearing && (reserved < RSP_CNT_W'(RSP_DEPTH));
      req_accept    = req_bus.valid && req_bus.ready;
      csr_bus.ready = 1'b1;
   end

   lgs_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .accept      (req_accept),
      .frame_start (req_bus.frame_start),
      .col         (col),
      .flags       (flags)
   );

   lgs_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (col),
      .cell_bit (req_bus.cell_alive),
      .clearing (clearing),
      .upper    (upper),
      .middle   (middle)
   );

   lgs_stencil u_stencil (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .cell_bit  (req_bus.cell_alive),
      .flags     (flags),
      .upper     (upper),
      .middle    (middle),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   lgs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (rsp_pop),
      .not_empty (not_empty),
      .head_item (head_item),
      .count     (queue_count)
   );

   // response channel
   always_comb begin
      rsp_bus.valid      = not_empty;
      rsp_pop            = not_empty && rsp_bus.ready;
      rsp_bus.next_alive = head_item.next_alive;
      rsp_bus.row_done   = head_item.row_done;
      rsp_bus.frame_done = head_item.frame_done;
   end

endmodule

// File: design/lgs_position.sv
// grid size registers and raster position tracking
module lgs_position import lgs_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   input  logic                   accept,
   input  logic                   frame_start,
   output logic [CW-1:0]          col,
   output cell_flags_type         flags
);

   localparam int SW = ((CW + 1) > CFG_W) ? (CW + 1) : CFG_W;
   localparam int SH = ((RW + 1) > CFG_W) ? (RW + 1) : CFG_W;

   logic [CFG_W-1:0] grid_width_ff, grid_width_in;
   logic [CFG_W-1:0] grid_height_ff, grid_height_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;

   logic [SW-1:0] gw_ext, w_last_wide;
   logic [SH-1:0] gh_ext, h_last_wide;
   logic [CW-1:0] w_last, col_cur;
   logic [RW-1:0] h_last, row_cur;
   logic          row_end;

   // configuration writes, unknown indexes ignored
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  grid_width_in  = csr_data;
            CSR_GRID_HEIGHT: grid_height_in = csr_data;
            default: ;
         endcase
      end
   end

   // effective last column and row, size saturated into the legal range
   always_comb begin
      gw_ext = SW'(grid_width_ff);
      gh_ext = SH'(grid_height_ff);
      priority if (gw_ext < SW'(MIN_GRID)) begin
         w_last_wide = SW'(MIN_GRID - 1);
      end else if (gw_ext > SW'(MAX_WIDTH)) begin
         w_last_wide = SW'(MAX_WIDTH - 1);
      end else begin
         w_last_wide = gw_ext - SW'(1);
      end
      priority if (gh_ext < SH'(MIN_GRID)) begin
         h_last_wide = SH'(MIN_GRID - 1);
      end else if (gh_ext > SH'(MAX_HEIGHT)) begin
         h_last_wide = SH'(MAX_HEIGHT - 1);
      end else begin
         h_last_wide = gh_ext - SH'(1);
      end
      w_last = w_last_wide[CW-1:0];
      h_last = h_last_wide[RW-1:0];
   end

   // position of the incoming cell and its result flags
   always_comb begin
      col_cur          = frame_start ? '0 : col_ff;
      row_cur          = frame_start ? '0 : row_ff;
      row_end          = (col_cur == w_last);
      flags.produce    = (row_cur >= RW'(2)) && (col_cur >= CW'(2)) &&
                         (row_cur <= h_last) && (col_cur <= w_last);
      flags.row_done   = row_end;
      flags.frame_done = row_end && (row_cur == h_last);
      col              = col_cur;
   end

   // raster advance with wrap at the row and frame ends
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_cur >= w_last) begin
            col_in = '0;
            row_in = (row_cur >= h_last) ? '0 : row_cur + RW'(1);
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_RESET;
         grid_height_ff <= GRID_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
      end
   end

endmodule

// File: design/lgs_line_buffer.sv
// two row line buffers in one memory, read-modify-write per cell
module lgs_line_buffer import lgs_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [CW-1:0] rd_addr,
   input  logic          cell_bit,
   output logic          clearing,
   output logic          upper,
   output logic          middle
);

   // word is {upper row bit, middle row bit}
   logic [1:0] line_mem [MAX_WIDTH];

   logic          clr_ff, clr_in;
   logic [CW-1:0] clr_addr_ff, clr_addr_in;
   logic          s_valid_ff;
   logic [CW-1:0] s_addr_ff;
   logic          s_cell_ff;
   logic [1:0]    rdata_ff;
   logic          fwd_valid_ff;
   logic [CW-1:0] fwd_addr_ff;
   logic [1:0]    fwd_data_ff;

   logic [1:0]    line_word;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   logic [1:0]    wr_data;

   // clearing pass after reset, one entry per cycle
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == CW'(MAX_WIDTH - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + CW'(1);
         end
      end
   end

   // read data, bypassed from the write of the previous cycle on an address match
   always_comb begin
      line_word = (fwd_valid_ff && (fwd_addr_ff == s_addr_ff)) ? fwd_data_ff : rdata_ff;
      upper     = line_word[1];
      middle    = line_word[0];
   end

   // write port: middle moves up, new cell becomes middle
   always_comb begin
      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = 2'b00;
      end else begin
         wr_en   = s_valid_ff;
         wr_addr = s_addr_ff;
         wr_data = {line_word[0], s_cell_ff};
      end
   end

   // memory
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= line_mem[rd_addr];
      end
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         s_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         s_valid_ff   <= rd_en;
         fwd_valid_ff <= s_valid_ff && !clr_ff;
      end
   end

   // payload of the read stage and the bypass
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s_addr_ff <= rd_addr;
         s_cell_ff <= cell_bit;
      end
      fwd_addr_ff <= s_addr_ff;
      fwd_data_ff <= wr_data;
   end

   assign clearing = clr_ff;

endmodule

// File: design/lgs_stencil.sv
// sliding 3x3 window and life rule evaluation
module lgs_stencil import lgs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           cell_bit,
   input  cell_flags_type flags,
   input  logic           upper,
   input  logic           middle,
   output logic           busy,
   output logic           push,
   output rsp_item_type   push_item
);

   logic           b_valid_ff;
   logic           b_cell_ff;
   cell_flags_type b_flags_ff;
   logic [8:0]     window_ff, window_in;

   // newest column enters at the low bits
   always_comb begin
      window_in = {window_ff[5:0], upper, middle, b_cell_ff};
   end

   // result for the window center
   always_comb begin
      push                 = b_valid_ff && b_flags_ff.produce;
      push_item.next_alive = life_rule(window_in);
      push_item.row_done   = b_flags_ff.row_done;
      push_item.frame_done = b_flags_ff.frame_done;
      busy                 = b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         window_ff  <= '0;
      end else begin
         b_valid_ff <= accept;
         if (b_valid_ff) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_cell_ff  <= cell_bit;
         b_flags_ff <= flags;
      end
   end

endmodule

// File: design/lgs_rsp_fifo.sv
// small response queue decoupling the pipeline from output stalls
module lgs_rsp_fifo import lgs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_item_type         push_item,
   input  logic                 pop,
   output logic                 not_empty,
   output rsp_item_type         head_item,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_item_type         queue_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   // occupancy
   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + RSP_CNT_W'(1);
         2'b01:   count_in = count_ff - RSP_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= push_item;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_item = queue_mem[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// File: verif/tb_top.sv
// testbench for the life generation stencil: raster stimulus, b3/s23 prediction, result check
`timescale 1ns / 1ps

module tb_top;
   import lgs_pkg::*;

   localparam int GRID_MAX     = 1024;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_CAP    = 40;

   // indexes past the register list, writes to them must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // window bits around the center cell
   localparam logic [8:0] NEIGHBOR_MASK = 9'h1EF;

   // 3x3 frames in raster order, first cell in bit 8
   localparam logic [8:0] PAT_BIRTH       = 9'b110_000_100;
   localparam logic [8:0] PAT_SURVIVE_TWO = 9'b100_110_000;
   localparam logic [8:0] PAT_CROWDED     = 9'b111_111_111;

   typedef struct {
      logic cell_alive;
      logic frame_start;
      bit   hold_off;
   } raster_cell_type;

   logic clock;
   logic reset;

   lgs_req_if req_if ();
   lgs_rsp_if rsp_if ();
   lgs_csr_if csr_if ();

   life_generation_stencil_top #(
      .MAX_WIDTH  (GRID_MAX),
      .MAX_HEIGHT (GRID_MAX)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // predicted grid state
   logic             upper_row  [GRID_MAX] = '{default: 1'b0};
   logic             middle_row [GRID_MAX] = '{default: 1'b0};
   logic [8:0]       window_q   = '0;
   int unsigned      col_pos    = 0;
   int unsigned      row_pos    = 0;
   logic [CFG_W-1:0] width_reg  = GRID_RESET;
   logic [CFG_W-1:0] height_reg = GRID_RESET;

   raster_cell_type cell_queue [$];
   rsp_item_type    next_gen_queue [$];

   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int unsigned errors = 0;
   int unsigned cells_sent = 0;
   int unsigned results_seen = 0;
   int unsigned csr_writes = 0;

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw);
      if (raw < MIN_GRID) return MIN_GRID;
      if (raw > GRID_MAX) return GRID_MAX;
      return raw;
   endfunction

   function automatic int unsigned draw_pause(input bit calm);
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   // advance the raster position by one cell and queue the next-generation result if any
   function automatic void step_grid(input logic alive, input logic fresh);
      int unsigned  w;
      int unsigned  h;
      int unsigned  nb;
      logic         up;
      logic         mid;
      rsp_item_type r;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      if (fresh) begin
         col_pos = 0;
         row_pos = 0;
      end
      up  = upper_row[col_pos];
      mid = middle_row[col_pos];
      upper_row[col_pos]  = mid;
      middle_row[col_pos] = alive;
      window_q = {window_q[5:0], up, mid, alive};
      // only interior cells whose window is complete give a result
      if (row_pos >= 2 && col_pos >= 2 && row_pos <= h - 1 && col_pos <= w - 1) begin
         nb = $countones(window_q & NEIGHBOR_MASK);
         r.next_alive = (nb == BIRTH_COUNT) || (nb == SURVIVE_COUNT && window_q[4]);
         r.row_done   = (col_pos == w - 1);
         r.frame_done = r.row_done && (row_pos == h - 1);
         next_gen_queue.push_back(r);
      end
      // wrap at the end of a row or frame, also when the size shrank below the position
      if (col_pos >= w - 1) begin
         col_pos = 0;
         row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("tb_top: mismatch at result %0d: %s", results_seen, msg);
   endtask

   task automatic push_cell(input logic alive, input logic fresh, input bit hold);
      raster_cell_type c;
      c.cell_alive  = alive;
      c.frame_start = fresh;
      c.hold_off    = hold;
      cell_queue.push_back(c);
   endtask

   task automatic push_pattern(input logic [8:0] cells, input bit fresh);
      for (int i = 8; i >= 0; i--) push_cell(cells[i], fresh && i == 8, 1'b0);
   endtask

   // one frame, or its first part, with a random fill density
   task automatic queue_frame(input int unsigned n_cells, input bit fresh);
      int unsigned density;
      bit          hold;
      density = $urandom_range(0, 3) * 25 + 10;
      hold = ($urandom_range(0, 15) == 0);
      for (int unsigned i = 0; i < n_cells; i++) begin
         push_cell($urandom_range(0, 99) < density, fresh && i == 0, hold && i == 0);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_if.index <= idx;
      csr_if.data  <= val;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CSR_GRID_WIDTH) width_reg = val;
      else if (idx == CSR_GRID_HEIGHT) height_reg = val;
      csr_writes++;
   endtask

   // block is idle once every cell is in and every result is out
   task automatic wait_idle();
      do @(posedge clock);
      while (cell_queue.size() != 0 || req_if.valid || next_gen_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one geometry: mostly whole frames, some wrapped frames and noise, maybe a partial tail
   task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                            input int unsigned n_cells);
      int unsigned w;
      int unsigned h;
      int unsigned sent;
      int unsigned kind;
      int unsigned burst;
      int unsigned frame_len;
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_GRID_WIDTH, w_raw);
         write_csr(CSR_GRID_HEIGHT, h_raw);
      end else begin
         write_csr(CSR_GRID_HEIGHT, h_raw);
         write_csr(CSR_GRID_WIDTH, w_raw);
      end
      if ($urandom_range(0, 2) == 0) begin
         write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, CFG_W'($urandom));
      end
      w = clamp_dim(w_raw);
      h = clamp_dim(h_raw);
      // frames larger than the cell budget are cut short
      frame_len = (w * h > n_cells) ? n_cells : w * h;
      sent = 0;
      while (sent < n_cells) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            burst = $urandom_range(1, 2 * w);
            repeat (burst) push_cell(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0, 1'b0);
            sent += burst;
         end else begin
            queue_frame(frame_len, kind > 2);
            sent += frame_len;
         end
      end
      // leave the position mid-frame so the next resize lands there
      if ($urandom_range(0, 1)) begin
         push_cell(1'($urandom_range(0, 1)), 1'b1, 1'b0);
         repeat ($urandom_range(0, frame_len - 2)) push_cell(1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end
      wait_idle();
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #12_000_000;
      $display("tb_top: timeout with %0d results outstanding", next_gen_queue.size());
      $display("tb_top: FAIL");
      $finish;
   end

   // request driver
   always @(posedge clock) begin : cell_driver
      raster_cell_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            step_grid(req_if.cell_alive, req_if.frame_start);
            cells_sent++;
            if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap != 0) begin
               req_if.valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (cell_queue.size() != 0 &&
                         !(cell_queue[0].hold_off && next_gen_queue.size() != 0)) begin
               nxt = cell_queue.pop_front();
               req_if.valid       <= 1'b1;
               req_if.cell_alive  <= nxt.cell_alive;
               req_if.frame_start <= nxt.frame_start;
               req_gap <= draw_pause(req_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : result_monitor
      rsp_item_type want;
      int unsigned  pause;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (next_gen_queue.size() == 0) begin
            report_mismatch("transaction with no result outstanding");
         end else begin
            want = next_gen_queue.pop_front();
            if (rsp_if.next_alive !== want.next_alive)
               report_mismatch($sformatf("next_alive got %0b expected %0b",
                                         rsp_if.next_alive, want.next_alive));
            if (rsp_if.row_done !== want.row_done)
               report_mismatch($sformatf("row_done got %0b expected %0b",
                                         rsp_if.row_done, want.row_done));
            if (rsp_if.frame_done !== want.frame_done)
               report_mismatch($sformatf("frame_done got %0b expected %0b",
                                         rsp_if.frame_done, want.frame_done));
         end
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         pause = draw_pause(rsp_calm);
         rsp_if.ready <= (pause == 0);
         rsp_hold <= pause;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_if.ready <= (rsp_hold == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      logic [CFG_W-1:0] w_raw;
      logic [CFG_W-1:0] h_raw;
      reset = 1'b1;
      req_if.valid       = 1'b0;
      req_if.cell_alive  = 1'b0;
      req_if.frame_start = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = CSR_GRID_WIDTH;
      csr_if.data        = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: part of the first row, no result may appear
      push_cell(1'($urandom_range(0, 1)), 1'b1, 1'b0);
      repeat (99) push_cell(1'($urandom_range(0, 1)), 1'b0, 1'b0);
      wait_idle();

      // minimum grid via sizes below range: birth, survival on two, early restart, crowding
      write_csr(CSR_GRID_WIDTH, '0);
      write_csr(CSR_GRID_HEIGHT, CFG_W'(2));
      push_pattern(PAT_BIRTH, 1'b1);
      push_pattern(PAT_SURVIVE_TWO, 1'b0);
      push_cell(1'b1, 1'b1, 1'b0);
      push_cell(1'b0, 1'b0, 1'b0);
      push_pattern(PAT_CROWDED, 1'b1);
      wait_idle();

      // random small geometries, with saturated wide and tall sizes in between
      for (int p = 0; p < 8; p++) begin
         if (p == 3) run_phase(CFG_W'(2047), '0, 200);
         if (p == 6) run_phase(CFG_W'(1), CFG_W'(1500), 250);
         w_raw = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 2)) :
                                               CFG_W'($urandom_range(3, 12));
         h_raw = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 2)) :
                                               CFG_W'($urandom_range(3, 9));
         run_phase(w_raw, h_raw, 80);
      end

      $display("tb_top: %0d cells in, %0d next-generation results checked, %0d register writes",
               cells_sent, results_seen, csr_writes);
      $display("tb_top: small grids, clamped sizes up to 1024, early restarts, resizes mid-frame");
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
